@@ sv/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared constants, types and helper functions of the SHA-1 digest engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 3;
    localparam int INDEX_W    = 3;
    localparam int LEN_W      = 64;
    localparam int HASH_WORDS = 5;
    localparam int BLK_WORDS  = 16;
    localparam int ROUNDS     = 80;
    localparam int ROUND_W    = 7;
    localparam int POS_W      = 4;

    typedef logic [WORD_W-1:0] word_t;

    // Initial hash values.
    localparam word_t H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam word_t MARK_WORD = 32'h80000000;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;
    localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'(ROUNDS - 1);

    // Source of the word that goes into the message window.
    typedef enum logic [2:0] {
        PUSH_INPUT  = 3'd0,
        PUSH_FIRST  = 3'd1,
        PUSH_MARK   = 3'd2,
        PUSH_ZERO   = 3'd3,
        PUSH_LEN_HI = 3'd4,
        PUSH_LEN_LO = 3'd5
    } push_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      push;
        push_sel_t push_sel;
        logic      take_last;
        logic      round_en;
        logic      update_en;
        logic      emit_en;
    } sha1_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_full;   // next push completes a block
        logic pad_end;      // window holds 14 words, length comes next
        logic round_last;   // round 79 is running
        logic count_full;   // final transaction carried four bytes
        logic out_busy;     // digest buffer still draining
    } sha1_status_t;

    // Keep mask for the valid leading bytes of a partial final word.
    function automatic word_t keep_mask(input logic [1:0] cnt);
        word_t m;
        m = '0;
        case (cnt)
            2'd0: m = 32'h00000000;
            2'd1: m = 32'hFF000000;
            2'd2: m = 32'hFFFF0000;
            default: m = 32'hFFFFFF00;
        endcase
        return m;
    endfunction

    // Marker byte placed right after the valid bytes.
    function automatic word_t mark_bits(input logic [1:0] cnt);
        word_t m;
        m = '0;
        case (cnt)
            2'd0: m = 32'h80000000;
            2'd1: m = 32'h00800000;
            2'd2: m = 32'h00008000;
            default: m = 32'h00000080;
        endcase
        return m;
    endfunction

    // Round function and constant for the 20-round groups.
    function automatic word_t round_f(input logic [1:0] grp, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        f = '0;
        case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd2: f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic word_t round_k(input logic [1:0] grp);
        word_t k;
        k = '0;
        case (grp)
            2'd0: k = K0;
            2'd1: k = K1;
            2'd2: k = K2;
            default: k = K3;
        endcase
        return k;
    endfunction

endpackage

@@ sv/sha1_if.sv @@
// ----------------------------------------------------------------------------
// sha1_if
// Valid/ready channels of the SHA-1 engine: message words in, digest words out.
// ----------------------------------------------------------------------------
interface sha1_msg_if;
    logic                           valid;
    logic                           ready;
    logic [sha1_pkg::WORD_W-1:0]    data_word;
    logic [sha1_pkg::COUNT_W-1:0]   byte_count;
    logic                           last_item;

    modport source (output valid, output data_word, output byte_count,
                    output last_item, input ready);
    modport sink (input valid, input data_word, input byte_count,
                  input last_item, output ready);
endinterface

interface sha1_dig_if;
    logic                           valid;
    logic                           ready;
    logic [sha1_pkg::WORD_W-1:0]    digest_word;
    logic [sha1_pkg::INDEX_W-1:0]   word_index;
    logic                           last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

@@ sv/sha1_dp.sv @@
// ----------------------------------------------------------------------------
// sha1_dp
// SHA-1 datapath: 16-word message window, round registers, chaining hash,
// bit length counter and the five-word digest output buffer.
// ----------------------------------------------------------------------------
module sha1_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sha1_pkg::sha1_cmd_t            cmd,
    output sha1_pkg::sha1_status_t         status,
    input  logic [sha1_pkg::WORD_W-1:0]    data_word,
    input  logic [sha1_pkg::COUNT_W-1:0]   byte_count,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [sha1_pkg::WORD_W-1:0]    digest_word,
    output logic [sha1_pkg::INDEX_W-1:0]   word_index,
    output logic                           last_word
);
    import sha1_pkg::*;

    word_t                w_reg [BLK_WORDS];
    word_t                var_reg [HASH_WORDS];
    word_t                hash_reg [HASH_WORDS];
    word_t                obuf_reg [HASH_WORDS];
    word_t                ldata_reg;
    logic [COUNT_W-1:0]   lcnt_reg;
    logic [LEN_W-1:0]     bitlen_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [ROUND_W-1:0]   rc_reg;
    logic [INDEX_W-1:0]   oidx_reg;
    logic                 ovalid_reg;

    logic [COUNT_W-1:0]   cnt_clamp;
    word_t                push_word;
    word_t                w_new;
    word_t                tmp;
    logic [1:0]           grp;
    logic                 out_fire;

    // Byte count of a final transaction, anything above four taken as four.
    assign cnt_clamp = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;

    // Word that enters the window on a push.
    always_comb
    begin
        push_word = '0;
        unique case (cmd.push_sel)
            PUSH_INPUT:  push_word = data_word;
            PUSH_FIRST:
            begin
                if (lcnt_reg == FULL_COUNT)
                    push_word = ldata_reg;
                else
                    push_word = (ldata_reg & keep_mask(lcnt_reg[1:0])) |
                                mark_bits(lcnt_reg[1:0]);
            end
            PUSH_MARK:   push_word = MARK_WORD;
            PUSH_ZERO:   push_word = '0;
            PUSH_LEN_HI: push_word = bitlen_reg[LEN_W-1:WORD_W];
            PUSH_LEN_LO: push_word = bitlen_reg[WORD_W-1:0];
            default:     push_word = '0;
        endcase
    end

    // Schedule expansion and one compression round.
    always_comb
    begin
        if (rc_reg < 7'd20)
            grp = 2'd0;
        else if (rc_reg < 7'd40)
            grp = 2'd1;
        else if (rc_reg < 7'd60)
            grp = 2'd2;
        else
            grp = 2'd3;
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[WORD_W-2:0], w_new[WORD_W-1]};
        tmp = {var_reg[0][WORD_W-6:0], var_reg[0][WORD_W-1:WORD_W-5]} +
              round_f(grp, var_reg[1], var_reg[2], var_reg[3]) +
              var_reg[4] + w_reg[0] + round_k(grp);
    end

    // Message window: shifts on every push and every round.
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round_en)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[BLK_WORDS-1] <= cmd.push ? push_word : w_new;
        end
        if (cmd.take_last)
        begin
            ldata_reg <= data_word;
            lcnt_reg  <= cnt_clamp;
        end
    end

    // Working variables: loaded from the chaining hash when a block fills.
    always_ff @(posedge clk)
    begin
        if (cmd.push && status.block_full)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
                var_reg[i] <= hash_reg[i];
        end
        else if (cmd.round_en)
        begin
            var_reg[4] <= var_reg[3];
            var_reg[3] <= var_reg[2];
            var_reg[2] <= {var_reg[1][1:0], var_reg[1][WORD_W-1:2]};
            var_reg[1] <= var_reg[0];
            var_reg[0] <= tmp;
        end
    end

    // Chaining hash, length, fill position and round counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
                hash_reg[i] <= H_INIT[i];
            bitlen_reg <= '0;
            pos_reg    <= '0;
            rc_reg     <= '0;
        end
        else
        begin
            if (cmd.update_en)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                    hash_reg[i] <= hash_reg[i] + var_reg[i];
            end
            else if (cmd.emit_en)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                    hash_reg[i] <= H_INIT[i];
            end

            if (cmd.emit_en)
                bitlen_reg <= '0;
            else if (cmd.take_last)
                bitlen_reg <= bitlen_reg + LEN_W'({cnt_clamp, 3'b000});
            else if (cmd.push && cmd.push_sel == PUSH_INPUT)
                bitlen_reg <= bitlen_reg + LEN_W'(WORD_W);

            if (cmd.push)
                pos_reg <= pos_reg + 4'd1;

            if (cmd.push && status.block_full)
                rc_reg <= '0;
            else if (cmd.round_en)
                rc_reg <= rc_reg + 7'd1;
        end
    end

    // Digest buffer: snapshot of the final hash, drained one word a transaction.
    assign out_fire = ovalid_reg && out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.emit_en)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
                obuf_reg[i] <= hash_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
        end
        else if (cmd.emit_en)
        begin
            ovalid_reg <= 1'b1;
            oidx_reg   <= '0;
        end
        else if (out_fire)
        begin
            if (oidx_reg == LAST_INDEX)
            begin
                ovalid_reg <= 1'b0;
                oidx_reg   <= '0;
            end
            else
                oidx_reg <= oidx_reg + 3'd1;
        end
    end

    assign out_valid   = ovalid_reg;
    assign digest_word = obuf_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == LAST_INDEX);

    // Status toward the controller.
    assign status.block_full = (pos_reg == 4'd15);
    assign status.pad_end    = (pos_reg == 4'd14);
    assign status.round_last = (rc_reg == LAST_ROUND);
    assign status.count_full = (lcnt_reg == FULL_COUNT);
    assign status.out_busy   = ovalid_reg;

endmodule

@@ sv/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1_ctrl
// SHA-1 controller: takes message transactions, sequences the padding words,
// runs the 80 rounds of each block and hands the digest to the output buffer.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_last,
    output logic                    in_ready,
    input  sha1_pkg::sha1_status_t  status,
    output sha1_pkg::sha1_cmd_t     cmd
);
    import sha1_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_FIRST  = 9'b000000010,
        ST_MARK   = 9'b000000100,
        ST_ZERO   = 9'b000001000,
        ST_LEN_HI = 9'b000010000,
        ST_LEN_LO = 9'b000100000,
        ST_ROUND  = 9'b001000000,
        ST_UPDATE = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // State sequencing; a push that fills the block detours through the rounds.
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd           = '0;
        cmd.push_sel  = PUSH_INPUT;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_last)
                    begin
                        cmd.take_last = 1'b1;
                        state_next    = ST_FIRST;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        if (status.block_full)
                        begin
                            ret_next   = ST_IDLE;
                            state_next = ST_ROUND;
                        end
                    end
                end
            end
            ST_FIRST:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_FIRST;
                ret_next     = status.count_full ? ST_MARK : ST_ZERO;
                state_next   = status.block_full ? ST_ROUND : ret_next;
            end
            ST_MARK:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_MARK;
                ret_next     = ST_ZERO;
                state_next   = status.block_full ? ST_ROUND : ST_ZERO;
            end
            ST_ZERO:
            begin
                if (status.pad_end)
                    state_next = ST_LEN_HI;
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_ZERO;
                    ret_next     = ST_ZERO;
                    if (status.block_full)
                        state_next = ST_ROUND;
                end
            end
            ST_LEN_HI:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_LEN_HI;
                state_next   = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_LEN_LO;
                ret_next     = ST_EMIT;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update_en = 1'b1;
                state_next    = ret_reg;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

@@ sv/sha1_digest.sv @@
// A non-final message word is taken while the controller is idle; each 16th word
// starts a compression that holds the input through 80 rounds, one a cycle, and
// the hash add, and the controller takes no word until the hash is updated.
// A final transaction costs the padding pushes plus one or two compressions
// before five digest transactions follow; the next message overlaps the drain.
// Reset (rst_n low, asynchronous) loads the initial hash and clears the counters.
// ----------------------------------------------------------------------------
// sha1_digest
// SHA-1 digest engine: gathers message words, pads, compresses and emits the
// five hash words of each message.
// ----------------------------------------------------------------------------
module sha1_digest (
    input  logic        clk,
    input  logic        rst_n,
    sha1_msg_if.sink    msg,
    sha1_dig_if.source  digest
);
    import sha1_pkg::*;

    sha1_cmd_t    cmd;
    sha1_status_t status;

    // Controller: handshake on the message channel and block sequencing.
    sha1_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .in_last  (msg.last_item),
        .in_ready (msg.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: window, rounds, hash and digest buffer.
    sha1_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_word   (msg.data_word),
        .byte_count  (msg.byte_count),
        .out_ready   (digest.ready),
        .out_valid   (digest.valid),
        .digest_word (digest.digest_word),
        .word_index  (digest.word_index),
        .last_word   (digest.last_word)
    );

endmodule

@@ sv/sha1_chk.sv @@
// ----------------------------------------------------------------------------
// sha1_chk
// Port-level checks of the SHA-1 engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           msg_valid,
    input logic                           msg_ready,
    input logic                           msg_last,
    input logic                           dig_valid,
    input logic                           dig_ready,
    input logic [sha1_pkg::WORD_W-1:0]    dig_word,
    input logic [sha1_pkg::INDEX_W-1:0]   dig_index,
    input logic                           dig_last
);
    import sha1_pkg::*;

    // A stalled digest transaction keeps its word and position.
    a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig_word) &&
                                    $stable(dig_index))
        else $error("digest word changed while stalled");

    // The final flag marks exactly the fifth word.
    a_dig_last: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> dig_last == (dig_index == LAST_INDEX))
        else $error("last_word does not match word_index");

    // Digest words follow one another in order without a gap in valid.
    a_dig_seq: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && dig_index != LAST_INDEX |=>
            dig_valid && dig_index == 3'($past(dig_index) + 3'd1))
        else $error("digest words out of order");

    // After the fifth word is taken, the buffer is empty in the next cycle.
    a_dig_end: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && dig_index == LAST_INDEX |=> !dig_valid)
        else $error("digest valid after final word");

    // A final message transaction is followed by padding, not a new transaction.
    a_msg_pad: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_last |=> !msg_ready)
        else $error("message taken during padding");

endmodule

bind sha1_digest sha1_chk u_sha1_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .msg_last  (msg.last_item),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_word  (digest.digest_word),
    .dig_index (digest.word_index),
    .dig_last  (digest.last_word)
);
